FILE: sv/quaternion_alu_unit_macros.svh
// Assertion macros for the quaternion ALU.
// Needs clk and rst_n in scope at the point of use; empty under SYNTHESIS.
`ifndef QUATERNION_ALU_UNIT_MACROS_SVH
`define QUATERNION_ALU_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define QA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define QA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QA_ASSERT_IMPLY(lbl, ante, cons, msg)
`define QA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/qalu_pkg.sv
// Shared types, constants and step functions of the quaternion ALU.
// No dependencies.
package qalu_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int PAIR_W     = 2 * WORD_W + 1;
  localparam int ACC_W      = 2 * WORD_W + 2;
  localparam int NUM_W      = WORD_W + FRAC_BITS;
  localparam int DEN_W      = WORD_W + 1;
  localparam int DIV_STAGES = NUM_W;
  localparam int SQ_IN_W    = 2 * DEN_W;
  localparam int SQ_STAGES  = DEN_W;
  localparam int SQ_REM_W   = DEN_W + 1;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_PROD  = 3'd4;
  localparam logic [2:0] OP_CONJ  = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-WORD_W){1'b0}}, WORD_MAX};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-WORD_W){1'b1}}, WORD_MIN};

  // Largest quotient magnitudes that still fit: 2^31-1 positive, 2^31 negative.
  localparam logic [NUM_W-1:0] QUO_POS_LIM = {{(NUM_W-WORD_W){1'b0}}, WORD_MAX};
  localparam logic [NUM_W-1:0] QUO_NEG_LIM = {{(NUM_W-WORD_W){1'b0}}, WORD_MIN};

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [3:0] quat_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } sat_word_t;

  typedef struct packed {
    logic [2:0]                  op;
    quat_t                       res;
    logic                        sat;
    logic                        err;
    logic [3:0]                  neg;
    logic [3:0][NUM_W-1:0]       num;
    word_t                       fabs;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] op;
    quat_t      res;
    logic       sat;
    logic       err;
    logic [3:0] neg;
  } dv_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } div_lane_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [DEN_W-1:0]    root;
    logic [SQ_IN_W-1:0]  x;
  } sq_lane_t;

  function automatic sat_word_t sat33(input logic signed [WORD_W:0] v);
    sat_word_t r;
    r.sat = (v[WORD_W] != v[WORD_W-1]);
    r.val = r.sat ? (v[WORD_W] ? WORD_MIN : WORD_MAX) : v[WORD_W-1:0];
    return r;
  endfunction

  // One restoring division step: bring in the next numerator bit, shift in a quotient bit.
  function automatic div_lane_t div_step(input logic [DEN_W-1:0] rem,
                                         input logic [NUM_W-1:0] nq,
                                         input logic [DEN_W-1:0] den);
    div_lane_t      r;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    trial = {rem, nq[NUM_W-1]};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      r.rem = diff[DEN_W-1:0];
      r.nq  = {nq[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DEN_W-1:0];
      r.nq  = {nq[NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One digit-by-digit square root step: two radicand bits in, one root bit out.
  function automatic sq_lane_t sqrt_step(input logic [SQ_REM_W-1:0] rem,
                                         input logic [DEN_W-1:0]    root,
                                         input logic [SQ_IN_W-1:0]  x);
    sq_lane_t              r;
    logic [SQ_REM_W+1:0]   rem2;
    logic [SQ_REM_W+1:0]   trial;
    logic [SQ_REM_W+1:0]   diff;
    rem2  = {rem, x[SQ_IN_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    diff  = rem2 - trial;
    if (rem2 >= trial) begin
      r.rem  = diff[SQ_REM_W-1:0];
      r.root = {root[DEN_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2[SQ_REM_W-1:0];
      r.root = {root[DEN_W-2:0], 1'b0};
    end
    r.x = {x[SQ_IN_W-3:0], 2'b00};
    return r;
  endfunction

endpackage

FILE: sv/quaternion_alu_unit.sv
// Quaternion ALU top level: front end, square root and divider pipelines, output register.
// Depends on qalu_pkg, qalu_front, qalu_sqrt, qalu_div and the assertion macros.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall   operation, a_*, b_*, factor
//   out_      output     out_valid / out_stall r_*, status
//
// One transaction enters per cycle unless the output stalls; every operation takes the
// same path: 4 front stages, 33 root stages, one divider stage per numerator bit,
// and the output register.
// Reset clears only valid bits. A stall of a valid output freezes the whole pipeline,
// and in_stall follows it in the same cycle.
`include "quaternion_alu_unit_macros.svh"
module quaternion_alu_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_factor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_r_w,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic [1:0]         out_status
);
  import qalu_pkg::*;

  logic                  en;
  quat_t                 a, b;
  logic                  sq_valid;
  sq_side_t              sq_side;
  logic [SQ_IN_W-1:0]    sq_in;
  logic                  rt_valid;
  sq_side_t              rt_side;
  logic [DEN_W-1:0]      rt_root;
  logic                  dv_valid;
  dv_side_t              dv_side;
  logic [3:0][NUM_W-1:0] dv_quo;
  logic                  use_div;
  quat_t                 r_nxt, r_r;
  logic [1:0]            status_nxt, status_r;
  logic                  out_valid_r;

  // advance only when the output register can take a new transaction
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign a = {in_a_z, in_a_y, in_a_x, in_a_w};
  assign b = {in_b_z, in_b_y, in_b_x, in_b_w};

  qalu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_op     (in_operation),
    .in_a      (a),
    .in_b      (b),
    .in_f      (in_factor),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_sq    (sq_in)
  );

  qalu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_sq     (sq_in),
    .out_valid (rt_valid),
    .out_side  (rt_side),
    .out_root  (rt_root)
  );

  qalu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rt_valid),
    .in_side   (rt_side),
    .in_root   (rt_root),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo)
  );

  assign use_div = dv_side.op inside {OP_DIV, OP_NORM};

  // Sign the quotient magnitudes and clip to 32 bits; other operations pass their front-end result, errors give zero.
  always_comb begin
    logic [3:0] over;
    logic       sat;
    over = '0;
    for (int l = 0; l < 4; l++) begin
      if (dv_side.neg[l]) begin
        over[l]  = (dv_quo[l] > QUO_NEG_LIM);
        r_nxt[l] = over[l] ? WORD_MIN : (word_t'(0) - dv_quo[l][WORD_W-1:0]);
      end else begin
        over[l]  = (dv_quo[l] > QUO_POS_LIM);
        r_nxt[l] = over[l] ? WORD_MAX : dv_quo[l][WORD_W-1:0];
      end
    end
    sat = |over;
    if (!use_div) begin
      r_nxt = dv_side.res;
      sat   = dv_side.sat;
    end
    if (dv_side.err) begin
      r_nxt      = '0;
      status_nxt = ST_ERR;
    end else begin
      status_nxt = sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r      <= r_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_r_w    = r_r[0];
  assign out_r_x    = r_r[1];
  assign out_r_y    = r_r[2];
  assign out_r_z    = r_r[3];
  assign out_status = status_r;

  `QA_ASSERT_IMPLY(a_err_zero, out_valid_r && status_r == ST_ERR, r_r == '0, "error result not zero")
  `QA_ASSERT_IMPLY(a_err_src, dv_valid && dv_side.err, dv_side.op == OP_DIV || dv_side.op == OP_NORM, "error flag on an operation that cannot fail")
  `QA_ASSERT_IMPLY(a_root_nz, rt_valid && rt_side.op == OP_NORM && !rt_side.err, rt_root != '0, "zero root for a nonzero quaternion")
  `QA_ASSERT_NEXT(a_stall_hold, in_stall, $stable(dv_valid) && $stable(rt_valid) && $stable(sq_valid), "pipeline moved during a stall")

endmodule

FILE: sv/qalu_front.sv
// Front end: input register, 16 multiplier lanes, two adder stages with rounding.
// Depends on qalu_pkg.
module qalu_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [2:0]                   in_op,
  input  qalu_pkg::quat_t              in_a,
  input  qalu_pkg::quat_t              in_b,
  input  qalu_pkg::word_t              in_f,
  output logic                         out_valid,
  output qalu_pkg::sq_side_t           out_side,
  output logic [qalu_pkg::SQ_IN_W-1:0] out_sq
);
  import qalu_pkg::*;

  // stage 1
  logic       v1_r;
  logic [2:0] op1_r;
  quat_t      a1_r, b1_r;
  word_t      f1_r;

  // stage 2
  logic [3:0][3:0][WORD_W-1:0]   mx, my;
  logic [3:0][3:0]               neg_nxt, neg2_r;
  logic [3:0][3:0][2*WORD_W-1:0] p2_nxt, p2_r;
  quat_t                         ew_nxt, ew2_r;
  logic                          ewsat_nxt, ewsat2_r;
  logic [3:0][NUM_W-1:0]         num_nxt, num2_r;
  logic [3:0]                    sgn_nxt, sgn2_r;
  word_t                         fabs_nxt, fabs2_r;
  logic                          fzero_nxt, fzero2_r;
  logic                          v2_r;
  logic [2:0]                    op2_r;

  // stage 3
  logic [3:0][PAIR_W-1:0] s01_nxt, s23_nxt, s01_r, s23_r;
  logic                   v3_r;
  logic [2:0]             op3_r;
  quat_t                  ew3_r;
  logic                   ewsat3_r;
  logic [3:0][NUM_W-1:0]  num3_r;
  logic [3:0]             sgn3_r;
  word_t                  fabs3_r;
  logic                   fzero3_r;

  // stage 4
  logic signed [ACC_W-1:0] tot [4];
  logic signed [ACC_W-1:0] rnd [4];
  quat_t                   rv;
  logic [3:0]              rs;
  sq_side_t                side_nxt, side_r;
  logic                    v4_r;
  logic [SQ_IN_W-1:0]      sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r    <= in_op;
      a1_r     <= in_a;
      b1_r     <= in_b;
      f1_r     <= in_f;
      op2_r    <= op1_r;
      p2_r     <= p2_nxt;
      neg2_r   <= neg_nxt;
      ew2_r    <= ew_nxt;
      ewsat2_r <= ewsat_nxt;
      num2_r   <= num_nxt;
      sgn2_r   <= sgn_nxt;
      fabs2_r  <= fabs_nxt;
      fzero2_r <= fzero_nxt;
      op3_r    <= op2_r;
      s01_r    <= s01_nxt;
      s23_r    <= s23_nxt;
      ew3_r    <= ew2_r;
      ewsat3_r <= ewsat2_r;
      num3_r   <= num2_r;
      sgn3_r   <= sgn2_r;
      fabs3_r  <= fabs2_r;
      fzero3_r <= fzero2_r;
      side_r   <= side_nxt;
      sq_r     <= tot[0];
    end
  end

  // Route operands to the multiplier lanes: lane [c][t] is term t of component c.
  always_comb begin
    mx      = '0;
    my      = '0;
    neg_nxt = '0;
    case (op1_r)
      OP_SCALE: begin
        for (int c = 0; c < 4; c++) begin
          mx[c][0] = a1_r[c];
          my[c][0] = f1_r;
        end
      end
      OP_PROD: begin
        mx[0][0] = a1_r[0]; my[0][0] = b1_r[0];
        mx[0][1] = a1_r[1]; my[0][1] = b1_r[1];
        mx[0][2] = a1_r[2]; my[0][2] = b1_r[2];
        mx[0][3] = a1_r[3]; my[0][3] = b1_r[3];
        mx[1][0] = a1_r[0]; my[1][0] = b1_r[1];
        mx[1][1] = b1_r[0]; my[1][1] = a1_r[1];
        mx[1][2] = a1_r[2]; my[1][2] = b1_r[3];
        mx[1][3] = a1_r[3]; my[1][3] = b1_r[2];
        mx[2][0] = a1_r[0]; my[2][0] = b1_r[2];
        mx[2][1] = b1_r[0]; my[2][1] = a1_r[2];
        mx[2][2] = a1_r[3]; my[2][2] = b1_r[1];
        mx[2][3] = a1_r[1]; my[2][3] = b1_r[3];
        mx[3][0] = a1_r[0]; my[3][0] = b1_r[3];
        mx[3][1] = b1_r[0]; my[3][1] = a1_r[3];
        mx[3][2] = a1_r[1]; my[3][2] = b1_r[2];
        mx[3][3] = a1_r[2]; my[3][3] = b1_r[1];
        neg_nxt[0] = 4'b1110;
        neg_nxt[1] = 4'b1000;
        neg_nxt[2] = 4'b1000;
        neg_nxt[3] = 4'b1000;
      end
      OP_NORM: begin
        for (int c = 0; c < 4; c++) begin
          mx[0][c] = a1_r[c];
          my[0][c] = a1_r[c];
        end
      end
      default: ;
    endcase
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        p2_nxt[c][t] = $signed(mx[c][t]) * $signed(my[c][t]);
      end
    end
  end

  // Add, subtract and conjugate finish here; prepare divider numerators.
  always_comb begin
    sat_word_t   sw;
    logic [WORD_W-1:0] mag;
    ew_nxt    = '0;
    ewsat_nxt = 1'b0;
    for (int c = 0; c < 4; c++) begin
      case (op1_r)
        OP_ADD:  sw = sat33({a1_r[c][WORD_W-1], a1_r[c]} + {b1_r[c][WORD_W-1], b1_r[c]});
        OP_SUB:  sw = sat33({a1_r[c][WORD_W-1], a1_r[c]} - {b1_r[c][WORD_W-1], b1_r[c]});
        OP_CONJ: begin
          if (c == 0) begin
            sw.sat = 1'b0;
            sw.val = a1_r[c];
          end else begin
            sw = sat33({(WORD_W+1){1'b0}} - {a1_r[c][WORD_W-1], a1_r[c]});
          end
        end
        default: sw = '0;
      endcase
      ew_nxt[c] = sw.val;
      ewsat_nxt = ewsat_nxt | sw.sat;
      mag = a1_r[c][WORD_W-1] ? (word_t'(0) - a1_r[c]) : a1_r[c];
      num_nxt[c] = {mag, {FRAC_BITS{1'b0}}};
      sgn_nxt[c] = (op1_r == OP_DIV) ? (a1_r[c][WORD_W-1] ^ f1_r[WORD_W-1])
                                     : a1_r[c][WORD_W-1];
    end
    fabs_nxt  = f1_r[WORD_W-1] ? (word_t'(0) - f1_r) : f1_r;
    fzero_nxt = (f1_r == '0);
  end

  // First adder level: apply term signs, sum pairs.
  always_comb begin
    logic signed [PAIR_W-1:0] term [4];
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        term[t] = $signed({p2_r[c][t][2*WORD_W-1], p2_r[c][t]});
        if (neg2_r[c][t]) begin
          term[t] = -term[t];
        end
      end
      s01_nxt[c] = term[0] + term[1];
      s23_nxt[c] = term[2] + term[3];
    end
  end

  // Second adder level: exact sum, round half up, saturate.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tot[c] = $signed({s01_r[c][PAIR_W-1], s01_r[c]}) + $signed({s23_r[c][PAIR_W-1], s23_r[c]});
      rnd[c] = (tot[c] + RND_HALF) >>> FRAC_BITS;
      if (rnd[c] > ACC_MAX) begin
        rv[c] = WORD_MAX;
        rs[c] = 1'b1;
      end else if (rnd[c] < ACC_MIN) begin
        rv[c] = WORD_MIN;
        rs[c] = 1'b1;
      end else begin
        rv[c] = rnd[c][WORD_W-1:0];
        rs[c] = 1'b0;
      end
    end
    side_nxt.op   = op3_r;
    side_nxt.res  = '0;
    side_nxt.sat  = 1'b0;
    side_nxt.err  = 1'b0;
    side_nxt.neg  = sgn3_r;
    side_nxt.num  = num3_r;
    side_nxt.fabs = fabs3_r;
    case (op3_r)
      OP_ADD, OP_SUB, OP_CONJ: begin
        side_nxt.res = ew3_r;
        side_nxt.sat = ewsat3_r;
      end
      OP_SCALE, OP_PROD: begin
        side_nxt.res = rv;
        side_nxt.sat = |rs;
      end
      OP_DIV:  side_nxt.err = fzero3_r;
      OP_NORM: side_nxt.err = (tot[0] == '0);
      default: ;
    endcase
  end

  assign out_valid = v4_r;
  assign out_side  = side_r;
  assign out_sq    = sq_r;

endmodule

FILE: sv/qalu_sqrt.sv
// Pipelined integer square root, one root bit per stage, side data carried along.
// Depends on qalu_pkg.
module qalu_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  qalu_pkg::sq_side_t           in_side,
  input  logic [qalu_pkg::SQ_IN_W-1:0] in_sq,
  output logic                         out_valid,
  output qalu_pkg::sq_side_t           out_side,
  output logic [qalu_pkg::DEN_W-1:0]   out_root
);
  import qalu_pkg::*;

  logic [SQ_STAGES-1:0] vld_r;
  sq_side_t             side_r   [SQ_STAGES];
  sq_lane_t             lane_r   [SQ_STAGES];
  sq_lane_t             lane_nxt [SQ_STAGES];

  always_comb begin
    lane_nxt[0] = sqrt_step('0, '0, in_sq);
    for (int k = 1; k < SQ_STAGES; k++) begin
      lane_nxt[k] = sqrt_step(lane_r[k-1].rem, lane_r[k-1].root, lane_r[k-1].x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r    <= lane_nxt;
      side_r[0] <= in_side;
      for (int k = 1; k < SQ_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[SQ_STAGES-1];
  assign out_side  = side_r[SQ_STAGES-1];
  assign out_root  = lane_r[SQ_STAGES-1].root;

endmodule

FILE: sv/qalu_div.sv
// Pipelined four-lane restoring divider, one quotient bit per stage.
// Divisor is |factor| for divide and the root for normalize. Depends on qalu_pkg.
module qalu_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  qalu_pkg::sq_side_t                  in_side,
  input  logic [qalu_pkg::DEN_W-1:0]          in_root,
  output logic                                out_valid,
  output qalu_pkg::dv_side_t                  out_side,
  output logic [3:0][qalu_pkg::NUM_W-1:0]     out_quo
);
  import qalu_pkg::*;

  logic [DIV_STAGES-1:0] vld_r;
  logic [DEN_W-1:0]      den0;
  logic [DEN_W-1:0]      den_r    [DIV_STAGES-1];
  div_lane_t [3:0]       lane_r   [DIV_STAGES];
  div_lane_t [3:0]       lane_nxt [DIV_STAGES];
  dv_side_t              side0;
  dv_side_t              side_r   [DIV_STAGES];

  assign den0 = (in_side.op == OP_DIV) ? {1'b0, in_side.fabs} : in_root;

  assign side0.op  = in_side.op;
  assign side0.res = in_side.res;
  assign side0.sat = in_side.sat;
  assign side0.err = in_side.err;
  assign side0.neg = in_side.neg;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_nxt[0][l] = div_step('0, in_side.num[l], den0);
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      for (int l = 0; l < 4; l++) begin
        lane_nxt[k][l] = div_step(lane_r[k-1][l].rem, lane_r[k-1][l].nq, den_r[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r    <= lane_nxt;
      side_r[0] <= side0;
      den_r[0]  <= den0;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int k = 1; k < DIV_STAGES - 1; k++) begin
        den_r[k] <= den_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      out_quo[l] = lane_r[DIV_STAGES-1][l].nq;
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for quaternion_alu_unit: directed and random quaternion operations.
// Depends on qalu_pkg for operation and status codes; the scoreboard predicts every result.
`timescale 1ns / 100ps
module tb_top;
  import qalu_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] f;
  } qop_t;

  typedef struct {
    logic [31:0] r [4];
    logic [1:0]  st;
  } qres_t;

  class qalu_scoreboard;
    qres_t pending_q[$];
    int    errors;

    static function automatic logic [31:0] clip(input logic signed [127:0] v, inout bit sat);
      if (v > 128'sd2147483647) begin
        sat = 1;
        return WORD_MAX;
      end
      if (v < -128'sd2147483648) begin
        sat = 1;
        return WORD_MIN;
      end
      return v[31:0];
    endfunction

    static function automatic logic [31:0] round_clip(input logic signed [127:0] v,
                                                     inout bit sat);
      logic signed [127:0] s;
      s = (v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return clip(s, sat);
    endfunction

    static function automatic logic [127:0] root_floor(input logic [127:0] s);
      logic [127:0] x, r, bt;
      x = s;
      r = 0;
      for (int k = 40; k >= 0; k--) begin
        bt = 128'd1 << (2 * k);
        if (x >= r + bt) begin
          x = x - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
      end
      return r;
    endfunction

    static function automatic qres_t quat_predict(input qop_t t);
      qres_t               e;
      logic signed [127:0] a [4];
      logic signed [127:0] b [4];
      logic signed [127:0] f, n, s;
      bit                  sat, err;
      sat = 0;
      err = 0;
      for (int i = 0; i < 4; i++) begin
        a[i] = t.a[i];
        b[i] = t.b[i];
        e.r[i] = '0;
      end
      f = t.f;
      case (t.op)
        OP_ADD:   for (int i = 0; i < 4; i++) e.r[i] = clip(a[i] + b[i], sat);
        OP_SUB:   for (int i = 0; i < 4; i++) e.r[i] = clip(a[i] - b[i], sat);
        OP_SCALE: for (int i = 0; i < 4; i++) e.r[i] = round_clip(a[i] * f, sat);
        OP_DIV: begin
          if (f == 0) err = 1;
          else for (int i = 0; i < 4; i++) e.r[i] = clip((a[i] <<< FRAC_BITS) / f, sat);
        end
        OP_PROD: begin
          e.r[0] = round_clip(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], sat);
          e.r[1] = round_clip(a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - a[3]*b[2], sat);
          e.r[2] = round_clip(a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - a[1]*b[3], sat);
          e.r[3] = round_clip(a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - a[2]*b[1], sat);
        end
        OP_CONJ: begin
          e.r[0] = t.a[0];
          for (int i = 1; i < 4; i++) e.r[i] = clip(-a[i], sat);
        end
        OP_NORM: begin
          s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
          if (s == 0) begin
            err = 1;
          end else begin
            n = root_floor(s);
            for (int i = 0; i < 4; i++) e.r[i] = clip((a[i] <<< FRAC_BITS) / n, sat);
          end
        end
        default: ;
      endcase
      if (err) for (int i = 0; i < 4; i++) e.r[i] = '0;
      e.st = err ? ST_ERR : (sat ? ST_SAT : ST_OK);
      return e;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void note_input(input qop_t t);
      pending_q.push_back(quat_predict(t));
    endfunction

    task check_result(input qres_t g);
      qres_t e;
      if (pending_q.size() == 0) begin
        report("unexpected transaction", g.r[0], 0);
      end else begin
        e = pending_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (g.r[i] !== e.r[i]) report($sformatf("r[%0d]", i), g.r[i], e.r[i]);
        if (g.st !== e.st) report("status", g.st, e.st);
      end
    endtask
  endclass

  logic               clk, rst_n;
  logic               in_valid, in_stall, out_valid, out_stall;
  logic [2:0]         in_operation;
  logic signed [31:0] in_a_w, in_a_x, in_a_y, in_a_z;
  logic signed [31:0] in_b_w, in_b_x, in_b_y, in_b_z, in_factor;
  logic signed [31:0] out_r_w, out_r_x, out_r_y, out_r_z;
  logic [1:0]         out_status;

  qalu_scoreboard sb;
  bit             quiet;
  int             idle_cycles;

  localparam int WATCHDOG_LIMIT = 3000;

  quaternion_alu_unit dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_operation = '0;
    {in_a_w, in_a_x, in_a_y, in_a_z} = '0;
    {in_b_w, in_b_x, in_b_y, in_b_z} = '0;
    in_factor = '0;
  end

  // Watch both channels; an accepted transaction resets the watchdog.
  always @(posedge clk) begin
    qop_t  t;
    qres_t g;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        t.op = in_operation;
        t.a = '{in_a_w, in_a_x, in_a_y, in_a_z};
        t.b = '{in_b_w, in_b_x, in_b_y, in_b_z};
        t.f = in_factor;
        sb.note_input(t);
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        g.r = '{out_r_w, out_r_x, out_r_y, out_r_z};
        g.st = out_status;
        sb.check_result(g);
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = $urandom_range(1, 14);
      if (!quiet && $urandom_range(0, 2) == 0) repeat (n) @(negedge clk) out_stall <= 1;
      else repeat (n) @(negedge clk) out_stall <= 0;
    end
  end

  task automatic send_op(input qop_t t);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk) in_valid <= 0;
    @(negedge clk);
    in_valid <= 1;
    in_operation <= t.op;
    {in_a_w, in_a_x, in_a_y, in_a_z} <= {t.a[0], t.a[1], t.a[2], t.a[3]};
    {in_b_w, in_b_x, in_b_y, in_b_z} <= {t.b[0], t.b[1], t.b[2], t.b[3]};
    in_factor <= t.f;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3, 4, 5: return $urandom;
      default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  task automatic send_uniform(input logic [2:0] op, input logic signed [31:0] av,
                              input logic signed [31:0] bv, input logic signed [31:0] fv);
    qop_t t;
    t.op = op;
    t.a = '{av, av, av, av};
    t.b = '{bv, bv, bv, bv};
    t.f = fv;
    send_op(t);
  endtask

  initial begin
    qop_t t;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed: extremes, divide by zero, zero norm, unused code, negated minimum.
    send_uniform(OP_ADD, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_uniform(OP_ADD, 32'sh80000000, 32'sh80000000, 0);
    send_uniform(OP_SUB, 32'sh80000000, 32'sh7fffffff, 0);
    send_uniform(OP_SUB, 32'sh7fffffff, 32'sh80000000, 0);
    send_uniform(OP_SCALE, 32'sh80000000, 0, 32'sh80000000);
    send_uniform(OP_SCALE, 32'sh7fffffff, 0, 32'sh80000000);
    send_uniform(OP_SCALE, 32'sh00018000, 0, 32'sh00008000);
    send_uniform(OP_SCALE, -32'sh00000001, 0, 32'sh00008000);
    send_uniform(OP_DIV, 32'sh00030000, 0, 0);
    send_uniform(OP_DIV, 32'sh80000000, 0, -32'sd1);
    send_uniform(OP_DIV, 32'sh7fffffff, 0, 32'sh7fffffff);
    send_uniform(OP_PROD, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_uniform(OP_PROD, 32'sh80000000, 32'sh80000000, 0);
    send_uniform(OP_PROD, 32'sh00010000, 32'sh00020000, 0);
    send_uniform(OP_CONJ, 32'sh80000000, 0, 0);
    send_uniform(OP_CONJ, 32'sh7fffffff, 0, 0);
    send_uniform(OP_NORM, 0, 0, 0);
    send_uniform(OP_NORM, 32'sh80000000, 0, 0);
    send_uniform(OP_NORM, 32'sh7fffffff, 0, 0);
    send_uniform(OP_NORM, 32'sd1, 0, 0);
    send_uniform(3'd7, 32'sh12345678, 32'sh7fffffff, 32'sh1);

    for (int k = 0; k < 700; k++) begin
      if (k == 600) quiet = 1;
      t.op = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      for (int i = 0; i < 4; i++) begin
        t.a[i] = pick_word();
        t.b[i] = pick_word();
      end
      t.f = ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_word();
      if (t.op == OP_NORM && $urandom_range(0, 14) == 0) t.a = '{0, 0, 0, 0};
      send_op(t);
    end
    @(negedge clk) in_valid <= 0;

    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: quaternion_alu_unit.f
+incdir+sv
sv/qalu_pkg.sv
sv/qalu_front.sv
sv/qalu_sqrt.sv
sv/qalu_div.sv
sv/quaternion_alu_unit.sv
tb/tb_top.sv
